// ----- hdl/chained_hash_map_core_assert.svh -----
// ---------------------------------------------------------------------------
// chained_hash_map_core_assert
// assertion macros used by the hash map rtl
// ---------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_CORE_ASSERT_SVH
`define CHAINED_HASH_MAP_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define CHM_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("hash map assertion failed");

// next-cycle implication, disabled while in reset
`define CHM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("hash map assertion failed");

`endif

// ----- hdl/chm_pkg.sv -----
// ---------------------------------------------------------------------------
// chm_pkg
// types and constants of the chained hash map
// ---------------------------------------------------------------------------
package chm_pkg;

    localparam int BUCKETS      = 256;
    localparam int POOL_ENTRIES = 256;
    localparam int KEY_BITS     = 32;
    localparam int DATA_BITS    = 32;

    // bucket index is the low key bits, so BUCKETS is a power of two
    localparam int BUCKET_BITS  = $clog2(BUCKETS);
    localparam int IDX_BITS     = $clog2(POOL_ENTRIES);
    localparam int USED_BITS    = $clog2(POOL_ENTRIES + 1);

    typedef enum logic {
        CMD_FIND = 1'b0,
        CMD_PUT  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_HIT      = 2'd0,
        STAT_INSERTED = 2'd1,
        STAT_MISS     = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] value_in;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [DATA_BITS-1:0] value_out;
    } rsp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] value;
        logic [IDX_BITS-1:0]  link;
        logic                 link_valid;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_ENTRY,
        S_DONE
    } state_t;

endpackage

// ----- hdl/chm_ram.sv -----
// ---------------------------------------------------------------------------
// chm_ram
// simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/chained_hash_map_core.sv -----
// ---------------------------------------------------------------------------
// chained_hash_map_core
// key-value map with separately chained buckets in on-chip ram
// ---------------------------------------------------------------------------
// One request at a time: a find or put steps through accept, the bucket head
// read, one pool ram read per chain entry visited and the result hand-off.
// Each chain step waits on the registered read of the pool ram. A new
// request is taken while the previous response still waits in the output
// register. Bucket heads are empty right after reset through per-bucket
// valid flops; no clearing pass. Pool entries are allocated in order and
// never freed; once the pool is full, a put of a new key answers with the
// full status.
`include "chained_hash_map_core_assert.svh"

module chained_hash_map_core
    import chm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    state_t                 state_reg, state_next;
    req_t                   req_reg;
    logic [BUCKETS-1:0]     head_valid_reg, head_valid_next;
    logic                   hv_reg;
    logic [IDX_BITS-1:0]    cur_idx_reg, cur_idx_next;
    logic [USED_BITS-1:0]   used_reg, used_next;
    rsp_t                   res_reg, res_next;
    rsp_t                   rsp_reg;
    logic                   rsp_valid_reg, rsp_valid_next;

    logic                   accept;
    logic [BUCKET_BITS-1:0] req_bucket;
    logic [BUCKET_BITS-1:0] cur_bucket;
    logic [IDX_BITS-1:0]    head_rdata;
    logic                   head_wr_en;
    logic [IDX_BITS-1:0]    slot;
    logic                   pool_full;

    logic                   ent_rd_en;
    logic [IDX_BITS-1:0]    ent_rd_addr;
    logic                   ent_wr_en;
    logic [IDX_BITS-1:0]    ent_wr_addr;
    entry_t                 ent_wr_data;
    entry_t                 ent_rdata;
    logic [$bits(entry_t)-1:0] ent_rdata_raw;

    logic                   do_miss;
    logic                   alloc;
    rsp_t                   miss_rsp;
    logic                   load_out;

    assign accept     = req_valid && (state_reg == S_IDLE);
    assign req_stall  = (state_reg != S_IDLE);
    assign req_bucket = req.key[BUCKET_BITS-1:0];
    assign cur_bucket = req_reg.key[BUCKET_BITS-1:0];
    assign slot       = used_reg[IDX_BITS-1:0];
    assign pool_full  = (used_reg == USED_BITS'(POOL_ENTRIES));
    assign ent_rdata  = entry_t'(ent_rdata_raw);

    chm_ram #(
        .WIDTH (IDX_BITS),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .clk     (clk),
        .wr_en   (head_wr_en),
        .wr_addr (cur_bucket),
        .wr_data (slot),
        .rd_en   (accept),
        .rd_addr (req_bucket),
        .rd_data (head_rdata)
    );

    chm_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (POOL_ENTRIES)
    ) u_pool_ram (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rdata_raw)
    );

    // outcome when the key is not in the chain
    always_comb
    begin
        miss_rsp.value_out = '0;
        if (req_reg.cmd == CMD_FIND)
        begin
            miss_rsp.status = STAT_MISS;
        end
        else if (pool_full)
        begin
            miss_rsp.status = STAT_FULL;
        end
        else
        begin
            miss_rsp.status = STAT_INSERTED;
        end
    end

    assign alloc = do_miss && (req_reg.cmd == CMD_PUT) && !pool_full;

    always_comb
    begin
        state_next   = state_reg;
        cur_idx_next = cur_idx_reg;
        res_next     = res_reg;
        ent_rd_en    = 1'b0;
        ent_rd_addr  = cur_idx_reg;
        ent_wr_en    = 1'b0;
        ent_wr_addr  = cur_idx_reg;
        ent_wr_data  = ent_rdata;
        do_miss      = 1'b0;
        load_out     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (hv_reg)
                begin
                    ent_rd_en    = 1'b1;
                    ent_rd_addr  = head_rdata;
                    cur_idx_next = head_rdata;
                    state_next   = S_ENTRY;
                end
                else
                begin
                    do_miss    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_ENTRY:
            begin
                if (ent_rdata.key == req_reg.key)
                begin
                    res_next.status = STAT_HIT;
                    if (req_reg.cmd == CMD_FIND)
                    begin
                        res_next.value_out = ent_rdata.value;
                    end
                    else
                    begin
                        res_next.value_out = '0;
                        ent_wr_en          = 1'b1;
                        ent_wr_data.value  = req_reg.value_in;
                    end
                    state_next = S_DONE;
                end
                else if (ent_rdata.link_valid)
                begin
                    ent_rd_en    = 1'b1;
                    ent_rd_addr  = ent_rdata.link;
                    cur_idx_next = ent_rdata.link;
                end
                else
                begin
                    do_miss    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_miss)
        begin
            res_next = miss_rsp;
        end

        // new entry goes to the chain head, linking the old head
        if (alloc)
        begin
            ent_wr_en              = 1'b1;
            ent_wr_addr            = slot;
            ent_wr_data.key        = req_reg.key;
            ent_wr_data.value      = req_reg.value_in;
            ent_wr_data.link       = head_rdata;
            ent_wr_data.link_valid = hv_reg;
        end
    end

    assign head_wr_en = alloc;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        used_next       = used_reg;
        if (alloc)
        begin
            head_valid_next[cur_bucket] = 1'b1;
            used_next                   = used_reg + USED_BITS'(1);
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_valid_reg <= '0;
            used_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_valid_reg <= head_valid_next;
            used_reg       <= used_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
            hv_reg  <= head_valid_reg[req_bucket];
        end
        cur_idx_reg <= cur_idx_next;
        res_reg     <= res_next;
        if (load_out)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `CHM_ASSERT_IMPLY(a_used_bound, clk, rst_n, 1'b1, used_reg <= USED_BITS'(POOL_ENTRIES))
    `CHM_ASSERT_IMPLY(a_alloc_not_full, clk, rst_n, alloc, !pool_full && hv_reg == hv_reg)
    `CHM_ASSERT_NEXT(a_alloc_counts, clk, rst_n, alloc, used_reg == $past(used_reg) + USED_BITS'(1))
    `CHM_ASSERT_NEXT(a_accept_head, clk, rst_n, accept, state_reg == S_HEAD)
    `CHM_ASSERT_NEXT(a_done_loads, clk, rst_n, load_out, rsp_valid_reg && state_reg == S_IDLE)

endmodule
